// ===== hw/rtl/omf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package omf_pkg;

  localparam int ACTION_W = 2;
  localparam int PORT_ID_W = 8;
  localparam int STATUS_W = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOCK    = 2'd0,
    ACT_TRYLOCK = 2'd1,
    ACT_UNLOCK  = 2'd2,
    ACT_DESTROY = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED        = 4'd0,
    ST_ALREADY        = 4'd1,
    ST_QUEUED         = 4'd2,
    ST_BUSY           = 4'd3,
    ST_RELEASED       = 4'd4,
    ST_HANDOFF        = 4'd5,
    ST_NOT_OWNER      = 4'd6,
    ST_DESTROY_LOCKED = 4'd7,
    ST_DESTROY_OK     = 4'd8,
    ST_QUEUE_FULL     = 4'd9
  } status_t;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [PORT_ID_W-1:0] requester;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 wake_valid;
    logic [PORT_ID_W-1:0] wake_id;
    logic                 held;
  } out_beat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/omf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface omf_in_if;
  logic             valid;
  logic             ready;
  omf_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface omf_out_if;
  logic               valid;
  logic               ready;
  omf_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/omf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module omf_cell #(
  parameter int W = 8
) (
  input  logic                clk,
  input  omf_pkg::cell_ctl_t  ctl,
  input  logic [W-1:0]        d_in,
  input  logic [W-1:0]        nb_in,
  output logic [W-1:0]        q
);
  import omf_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= d_in;
    end else if (ctl.shift) begin
      q <= nb_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/omf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module omf_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  omf_pkg::queue_ctl_t   ctl,
  input  logic [W-1:0]          din,
  output logic [W-1:0]          head,
  output omf_pkg::queue_stat_t  stat
);
  import omf_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [W-1:0]  cell_q [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push && !ctl.pop) begin
      count <= count + CW'(1);
    end else if (ctl.pop && !ctl.push) begin
      count <= count - CW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t     cctl;
    logic [W-1:0]  nb;

    assign cctl.load  = ctl.push && (count == CW'(i));
    assign cctl.shift = ctl.pop;

    if (i == DEPTH - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end

    omf_cell #(.W(W)) u_cell (
      .clk   (clk),
      .ctl   (cctl),
      .d_in  (din),
      .nb_in (nb),
      .q     (cell_q[i])
    );
  end

  assign head       = cell_q[0];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !stat.full)
    else $error("push into full queue");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (ctl.pop && !ctl.push) |=> (count == $past(count) - CW'(1)))
    else $error("pop did not decrement count");

endmodule

`default_nettype wire

// ===== hw/rtl/owner_mutex_fifo_handoff_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Mutex unit with a FIFO of waiters and direct hand-off of ownership. Each
// request beat (action, requester) yields exactly one result beat (status,
// wake_valid, wake_id, held). The flag, the owner
// register and the waiter queue are updated at the edge that accepts a request, and
// the result lands in an output register, so one request per cycle is taken
// while the result side keeps up; a stalled result holds off only the next
// request. The waiter queue is a row of QUEUE_DEPTH shift cells: a new waiter
// is written into the cell at the fill position and a hand-off shifts every
// cell one place toward the head. Requester bits above ID_BITS are ignored.
module owner_mutex_fifo_handoff_top #(
  parameter int ID_BITS     = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  omf_in_if.sink      in_ch,
  omf_out_if.source   out_ch
);
  import omf_pkg::*;

  logic               held;
  logic               held_next;
  logic [ID_BITS-1:0] owner;
  logic [ID_BITS-1:0] owner_next;
  logic [ID_BITS-1:0] req;
  logic [ID_BITS-1:0] head;
  logic [ID_BITS-1:0] wid;
  logic [PORT_ID_W-1:0] wid_port;
  logic               wv;
  status_t            status;
  logic               push;
  logic               pop;
  logic               accept;
  queue_ctl_t         qctl;
  queue_stat_t        qstat;
  logic               out_valid;
  out_beat_t          out_beat;

  if (ID_BITS >= PORT_ID_W) begin : g_wide
    assign req      = ID_BITS'(in_ch.data.requester);
    assign wid_port = wid[PORT_ID_W-1:0];
  end else begin : g_narrow
    assign req      = in_ch.data.requester[ID_BITS-1:0];
    assign wid_port = PORT_ID_W'(wid);
  end

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    held_next  = held;
    owner_next = owner;
    push       = 1'b0;
    pop        = 1'b0;
    wv         = 1'b0;
    wid        = '0;
    status     = ST_GRANTED;
    case (action_t'(in_ch.data.action))
      ACT_LOCK: begin
        if (!held) begin
          held_next  = 1'b1;
          owner_next = req;
          status     = ST_GRANTED;
        end else if (req == owner) begin
          status = ST_ALREADY;
        end else if (qstat.full) begin
          status = ST_QUEUE_FULL;
        end else begin
          push   = 1'b1;
          status = ST_QUEUED;
        end
      end
      ACT_TRYLOCK: begin
        if (!held) begin
          held_next  = 1'b1;
          owner_next = req;
          status     = ST_GRANTED;
        end else begin
          status = ST_BUSY;
        end
      end
      ACT_UNLOCK: begin
        if (!held || req != owner) begin
          status = ST_NOT_OWNER;
        end else if (!qstat.empty) begin
          owner_next = head;
          pop        = 1'b1;
          wv         = 1'b1;
          wid        = head;
          status     = ST_HANDOFF;
        end else begin
          held_next  = 1'b0;
          owner_next = '0;
          status     = ST_RELEASED;
        end
      end
      default: begin
        status = held ? ST_DESTROY_LOCKED : ST_DESTROY_OK;
      end
    endcase
  end

  assign qctl.push = accept && push;
  assign qctl.pop  = accept && pop;

  omf_queue #(.W(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctl  (qctl),
    .din  (req),
    .head (head),
    .stat (qstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      owner <= '0;
    end else if (accept) begin
      held  <= held_next;
      owner <= owner_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_beat.status     <= status;
      out_beat.wake_valid <= wv;
      out_beat.wake_id    <= wid_port;
      out_beat.held       <= held_next;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_beat;

  a_free_no_owner: assert property (@(posedge clk) disable iff (rst)
    !held |-> (owner == '0))
    else $error("free lock keeps an owner");

  a_wake_handoff: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_beat.wake_valid == (out_beat.status == ST_HANDOFF)))
    else $error("wake flag disagrees with status");

  a_handoff_owner: assert property (@(posedge clk) disable iff (rst)
    qctl.pop |=> (held && owner == $past(head)))
    else $error("hand-off did not pass ownership to queue head");

endmodule

`default_nettype wire

// ===== bench/tb_owner_mutex_fifo_handoff_top.sv =====
`timescale 1ns / 1ps

module tb_owner_mutex_fifo_handoff_top;
  import omf_pkg::*;

  localparam int QDEPTH     = 16;
  localparam int N_RANDOM   = 1150;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    action_t              act;
    logic [PORT_ID_W-1:0] id;
    bit                   typed;
    status_t              st;
    logic                 wv;
    logic [PORT_ID_W-1:0] wid;
    logic                 hd;
  } step_t;

  logic clk;
  logic rst;

  omf_in_if  in_ch ();
  omf_out_if out_ch ();

  owner_mutex_fifo_handoff_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // mutex state as the block should hold it
  bit                   lock_taken;
  logic [PORT_ID_W-1:0] owner_now;
  logic [PORT_ID_W-1:0] waiters [QDEPTH];
  int                   wait_head;
  int                   wait_tail;
  int                   wait_count;

  step_t     dir_steps[$];
  out_beat_t expected_results[$];
  logic [PORT_ID_W-1:0] fill_ids [14] = '{8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02,
                                          8'h01, 8'hAA, 8'h55, 8'hFE, 8'h7F, 8'h0F, 8'hF0};

  int n_issued;
  int n_taken;
  int n_total;
  int rand_made;
  int lock_pct;
  bit calm;
  int gap_left;
  int stall_left;
  int idle_cycles;
  int failures;
  out_beat_t predicted;
  out_beat_t want;

  function automatic out_beat_t serve_request(in_beat_t req);
    out_beat_t res;
    res = '0;
    case (action_t'(req.action))
      ACT_LOCK: begin
        if (!lock_taken) begin
          lock_taken = 1'b1;
          owner_now  = req.requester;
          res.status = ST_GRANTED;
        end else if (req.requester == owner_now) begin
          res.status = ST_ALREADY;
        end else if (wait_count >= QDEPTH) begin
          res.status = ST_QUEUE_FULL;
        end else begin
          waiters[wait_tail] = req.requester;
          wait_tail = (wait_tail + 1) % QDEPTH;
          wait_count++;
          res.status = ST_QUEUED;
        end
      end
      ACT_TRYLOCK: begin
        if (!lock_taken) begin
          lock_taken = 1'b1;
          owner_now  = req.requester;
          res.status = ST_GRANTED;
        end else begin
          res.status = ST_BUSY;
        end
      end
      ACT_UNLOCK: begin
        if (!lock_taken || req.requester != owner_now) begin
          res.status = ST_NOT_OWNER;
        end else if (wait_count > 0) begin
          owner_now = waiters[wait_head];
          wait_head = (wait_head + 1) % QDEPTH;
          wait_count--;
          res.status     = ST_HANDOFF;
          res.wake_valid = 1'b1;
          res.wake_id    = owner_now;
        end else begin
          lock_taken = 1'b0;
          owner_now  = '0;
          res.status = ST_RELEASED;
        end
      end
      default: begin
        res.status = lock_taken ? ST_DESTROY_LOCKED : ST_DESTROY_OK;
      end
    endcase
    res.held = lock_taken;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // mostly lock/unlock traffic around the real owner, with a tenth of pure noise
  function automatic in_beat_t random_request();
    in_beat_t b;
    int p;
    if (rand_made % 40 == 0) begin
      case ($urandom_range(2))
        0: lock_pct = 20;
        1: lock_pct = 45;
        default: lock_pct = 75;
      endcase
      calm = ($urandom_range(3) == 0);
    end
    rand_made++;
    b.requester = PORT_ID_W'($urandom_range(255));
    b.action    = ACTION_W'($urandom_range(3));
    if ($urandom_range(9) == 0) return b;
    p = $urandom_range(99);
    if (p < lock_pct) b.action = ACT_LOCK;
    else if (p < lock_pct + 10) b.action = ACT_TRYLOCK;
    else if (p < 92) b.action = ACT_UNLOCK;
    else b.action = ACT_DESTROY;
    if (b.action == ACT_UNLOCK && $urandom_range(99) < 80) begin
      b.requester = owner_now;
    end else if (b.action == ACT_LOCK && lock_taken && $urandom_range(99) < 15) begin
      b.requester = owner_now;
    end else if ($urandom_range(1) == 0) begin
      b.requester = PORT_ID_W'($urandom_range(7));
    end
    return b;
  endfunction

  task automatic add_step(action_t act, logic [PORT_ID_W-1:0] id, bit typed,
                          status_t st, logic wv, logic [PORT_ID_W-1:0] wid, logic hd);
    step_t s;
    s.act = act; s.id = id; s.typed = typed;
    s.st = st; s.wv = wv; s.wid = wid; s.hd = hd;
    dir_steps.push_back(s);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    lock_taken = 1'b0;
    owner_now  = '0;
    wait_head  = 0;
    wait_tail  = 0;
    wait_count = 0;
    failures   = 0;
    lock_pct   = 45;
    calm       = 1'b0;

    add_step(ACT_DESTROY, 8'h00, 1, ST_DESTROY_OK,     0, 8'h00, 0);
    add_step(ACT_UNLOCK,  8'h00, 1, ST_NOT_OWNER,      0, 8'h00, 0);
    add_step(ACT_TRYLOCK, 8'hFF, 1, ST_GRANTED,        0, 8'h00, 1);
    add_step(ACT_TRYLOCK, 8'hFF, 1, ST_BUSY,           0, 8'h00, 1);
    add_step(ACT_LOCK,    8'hFF, 1, ST_ALREADY,        0, 8'h00, 1);
    add_step(ACT_DESTROY, 8'h5A, 1, ST_DESTROY_LOCKED, 0, 8'h00, 1);
    add_step(ACT_UNLOCK,  8'h00, 1, ST_NOT_OWNER,      0, 8'h00, 1);
    // same waiter twice, then fill the queue
    add_step(ACT_LOCK,    8'h00, 0, ST_GRANTED,        0, 8'h00, 0);
    add_step(ACT_LOCK,    8'h00, 0, ST_GRANTED,        0, 8'h00, 0);
    foreach (fill_ids[i]) add_step(ACT_LOCK, fill_ids[i], 0, ST_GRANTED, 0, 8'h00, 0);
    add_step(ACT_LOCK,    8'h33, 1, ST_QUEUE_FULL,     0, 8'h00, 1);
    add_step(ACT_UNLOCK,  8'hFF, 0, ST_GRANTED,        0, 8'h00, 0);
    add_step(ACT_UNLOCK,  8'h00, 0, ST_GRANTED,        0, 8'h00, 0);
    n_total = dir_steps.size() + N_RANDOM;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (!(n_taken == n_total && expected_results.size() == 0)) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // request side
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = serve_request(in_ch.data);
        if (n_taken < dir_steps.size() && dir_steps[n_taken].typed) begin
          predicted.status     = dir_steps[n_taken].st;
          predicted.wake_valid = dir_steps[n_taken].wv;
          predicted.wake_id    = dir_steps[n_taken].wid;
          predicted.held       = dir_steps[n_taken].hd;
        end
        expected_results.push_back(predicted);
        n_taken++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (n_issued < n_total) begin
          if (n_issued < dir_steps.size()) begin
            in_ch.data <= '{action: dir_steps[n_issued].act, requester: dir_steps[n_issued].id};
          end else begin
            in_ch.data <= random_request();
          end
          in_ch.valid <= 1'b1;
          n_issued++;
          gap_left = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          failures++;
          $display("%0t: result beat with nothing pending, got %h", $time, out_ch.data);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.data.status !== want.status) begin
            failures++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_ch.data.status);
          end
          if (out_ch.data.wake_valid !== want.wake_valid) begin
            failures++;
            $display("%0t: wake_valid expected %0d actual %0d", $time, want.wake_valid,
                     out_ch.data.wake_valid);
          end
          if (out_ch.data.wake_id !== want.wake_id) begin
            failures++;
            $display("%0t: wake_id expected %h actual %h", $time, want.wake_id,
                     out_ch.data.wake_id);
          end
          if (out_ch.data.held !== want.held) begin
            failures++;
            $display("%0t: held expected %0d actual %0d", $time, want.held,
                     out_ch.data.held);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(7) == 0) stall_left = pick_gap() + 1;
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
